[rtl/core/sifa_pkg.sv]
// Package for the string interning find-or-add block.
// Holds pool and query sizes, derived widths, the token type and the FIFO depth.
// No dependencies.
`timescale 1ns / 1ps

package sifa_pkg;

	localparam int POOL_BYTES = 1024;
	localparam int MAX_LEN    = 64;

	localparam int LEN_BITS   = 16;
	localparam int OFF_BITS   = 10;

	localparam int AW  = $clog2(POOL_BYTES);
	localparam int FW  = $clog2(POOL_BYTES + 2);
	localparam int LW  = $clog2(MAX_LEN + 1);
	localparam int QIW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int XW  = ((FW > LEN_BITS) ? FW : LEN_BITS) + 1;

	localparam int FIFO_DEPTH = 4;
	localparam int FP         = $clog2(FIFO_DEPTH);

	localparam int FREE_RESET = 4;
	localparam int HDR_BYTES  = 2;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       has_byte;
		logic       end_of_string;
		logic       overlong;
	} tok_t;

endpackage

[rtl/core/sifa_if.sv]
// Channel interfaces of the string interning block: query items in, results out.
// Depends on nothing; each carries valid, ready and the payload.
`timescale 1ns / 1ps

interface sifa_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       has_byte;
	logic       end_of_string;

	modport source(output valid, byte_value, has_byte, end_of_string, input ready);
	modport sink(input valid, byte_value, has_byte, end_of_string, output ready);
endinterface

interface sifa_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] string_offset;
	logic       was_added;
	logic       pool_full;
	logic       too_long;

	modport source(output valid, string_offset, was_added, pool_full, too_long, input ready);
	modport sink(input valid, string_offset, was_added, pool_full, too_long, output ready);
endinterface

[rtl/core/string_intern_find_or_add.sv]
// Top level of the string interning find-or-add block.
// Depends on sifa_pkg, sifa_if, sifa_front, sifa_fifo and sifa_back.
//
//   channel | dir | fields                                          | transfer
//   req     | in  | byte_value, has_byte, end_of_string             | valid && ready
//   rsp     | out | string_offset, was_added, pool_full, too_long   | valid && ready
//
// A byte item goes through the front end and the token queue into the back
// end. An end item walks the pool: it reads each record header and, on a
// length match, compares the stored bytes; an append checks the fit, then
// writes the length, the query bytes and a zero; a last step loads the result
// register. Reset needs no clearing pass: reads below the free mark see written
// data, the first four bytes read as zero. A four-entry token queue lets the
// front end keep taking items while the back end walks or waits on rsp.
`timescale 1ns / 1ps

module string_intern_find_or_add (
	input  logic       clk,
	input  logic       arst_n,
	sifa_in_if.sink    req,
	sifa_out_if.source rsp
);

	logic           fifo_push;
	sifa_pkg::tok_t fifo_in;
	logic           fifo_full;
	logic           head_valid;
	sifa_pkg::tok_t head_tok;
	logic           fifo_pop;

	sifa_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.push     (fifo_push),
		.push_tok (fifo_in),
		.full     (fifo_full)
	);

	sifa_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fifo_push),
		.push_tok   (fifo_in),
		.full       (fifo_full),
		.head_valid (head_valid),
		.head_tok   (head_tok),
		.pop        (fifo_pop)
	);

	sifa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (head_valid),
		.tok       (head_tok),
		.pop       (fifo_pop),
		.rsp       (rsp)
	);

	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> $countones({rsp.was_added, rsp.pool_full, rsp.too_long}) <= 1)
		else $error("more than one outcome flag in a result");

	a_flag_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.pool_full || rsp.too_long) |-> rsp.string_offset == '0)
		else $error("flagged result carries an offset");

	a_even_offset: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.pool_full && !rsp.too_long |-> !rsp.string_offset[0])
		else $error("string offset is odd");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_full && !fifo_pop |=> !fifo_push || fifo_full == 1'b0 || !req.ready)
		else $error("token pushed into a full queue");

endmodule

[rtl/core/sifa_front.sv]
// Front end: accepts query items, counts length, drops bytes past the limit.
// Depends on sifa_pkg and sifa_in_if; pushes tokens to the queue.
`timescale 1ns / 1ps

module sifa_front (
	input  logic           clk,
	input  logic           arst_n,
	sifa_in_if.sink        req,
	output logic           push,
	output sifa_pkg::tok_t push_tok,
	input  logic           full
);

	logic [sifa_pkg::LW-1:0] len_q;
	logic                    long_q;
	logic                    xfer;
	logic                    keep;

	assign req.ready = !full;
	assign xfer      = req.valid && req.ready;
	assign keep      = req.has_byte && (len_q < sifa_pkg::LW'(sifa_pkg::MAX_LEN));
	assign push      = xfer && (keep || req.end_of_string);

	assign push_tok.byte_value    = req.byte_value;
	assign push_tok.has_byte      = keep;
	assign push_tok.end_of_string = req.end_of_string;
	assign push_tok.overlong      = long_q || (req.has_byte && !keep);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			long_q <= 1'b0;
		end else if (xfer) begin
			if (req.end_of_string) begin
				len_q  <= '0;
				long_q <= 1'b0;
			end else begin
				if (keep)
					len_q <= len_q + sifa_pkg::LW'(1);
				if (req.has_byte && !keep)
					long_q <= 1'b1;
			end
		end
	end

endmodule

[rtl/core/sifa_fifo.sv]
// Short token queue between front and back end.
// Depends on sifa_pkg for the token type and depth.
`timescale 1ns / 1ps

module sifa_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  sifa_pkg::tok_t push_tok,
	output logic           full,
	output logic           head_valid,
	output sifa_pkg::tok_t head_tok,
	input  logic           pop
);

	sifa_pkg::tok_t          slot_q [sifa_pkg::FIFO_DEPTH];
	logic [sifa_pkg::FP-1:0] wr_q;
	logic [sifa_pkg::FP-1:0] rd_q;
	logic [sifa_pkg::FP:0]   cnt_q;
	logic                    do_push;
	logic                    do_pop;

	assign full       = (cnt_q == (sifa_pkg::FP + 1)'(sifa_pkg::FIFO_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_tok   = slot_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + sifa_pkg::FP'(1);
			if (do_pop)
				rd_q <= rd_q + sifa_pkg::FP'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + (sifa_pkg::FP + 1)'(1);
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - (sifa_pkg::FP + 1)'(1);
		end
	end

endmodule

[rtl/core/sifa_back.sv]
// Back end: buffers the query, walks the pool, appends and drives results.
// Depends on sifa_pkg and sifa_out_if; holds pool and query memories.
`timescale 1ns / 1ps

module sifa_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tok_valid,
	input  sifa_pkg::tok_t tok,
	output logic           pop,
	sifa_out_if.source     rsp
);

	typedef enum logic [3:0] {
		S_IDLE, S_LEN0, S_LEN1, S_LEN2, S_CMP, S_FIT, S_WLO, S_WHI, S_WCH, S_EMIT
	} state_t;

	localparam int AW  = sifa_pkg::AW;
	localparam int FW  = sifa_pkg::FW;
	localparam int LW  = sifa_pkg::LW;
	localparam int QIW = sifa_pkg::QIW;
	localparam int XW  = sifa_pkg::XW;
	localparam int LB  = sifa_pkg::LEN_BITS;
	localparam int OB  = sifa_pkg::OFF_BITS;

	logic [7:0]     pool_mem [sifa_pkg::POOL_BYTES];
	logic [7:0]     qbuf_mem [sifa_pkg::MAX_LEN];

	state_t         state_q;
	logic [FW-1:0]  free_q;
	logic [FW-1:0]  cur_q;
	logic [LW-1:0]  qlen_q;
	logic [LW-1:0]  k_q;
	logic           pend_q;
	logic [7:0]     len_lo_q;
	logic [LB-1:0]  len_q;
	logic [7:0]     rdata_q;
	logic           rlow_q;
	logic [7:0]     qdata_q;

	logic           rsp_valid_q;
	logic [OB-1:0]  off_q;
	logic           added_q;
	logic           full_q;
	logic           long_q;
	logic [OB-1:0]  out_off_q;
	logic           out_added_q;
	logic           out_full_q;
	logic           out_long_q;

	logic [XW-1:0]  raddr_x;
	logic [QIW-1:0] qaddr;
	logic           pool_we;
	logic [XW-1:0]  waddr_x;
	logic [7:0]     wdata;
	logic [7:0]     pool_rd;
	logic [LB-1:0]  len16;
	logic [LB-1:0]  len_sel;
	logic [LB-1:0]  qlen16;
	logic [XW-1:0]  nxt_x;
	logic [XW-1:0]  nxt_even;
	logic [XW-1:0]  need_x;
	logic [XW-1:0]  need_even;
	logic [XW-1:0]  hit_off;
	logic [XW-1:0]  new_off;
	logic [LW-1:0]  kp1;
	logic           walk_ok;
	logic           emit_ok;

	assign pool_rd   = rlow_q ? 8'd0 : rdata_q;
	assign len16     = {pool_rd, len_lo_q};
	assign qlen16    = LB'(qlen_q);
	assign len_sel   = (state_q == S_LEN2) ? len16 : len_q;
	assign nxt_x     = XW'(cur_q) + XW'(len_sel) + XW'(3);
	assign nxt_even  = nxt_x + XW'(nxt_x[0]);
	assign need_x    = XW'(free_q) + XW'(qlen_q) + XW'(3);
	assign need_even = need_x + XW'(need_x[0]);
	assign hit_off   = XW'(cur_q) + XW'(sifa_pkg::HDR_BYTES);
	assign new_off   = XW'(free_q) + XW'(sifa_pkg::HDR_BYTES);
	assign kp1       = k_q + LW'(1);
	assign walk_ok   = (cur_q < free_q) &&
		(XW'(cur_q) + XW'(2) <= XW'(sifa_pkg::POOL_BYTES));
	assign emit_ok   = !rsp_valid_q || rsp.ready;
	assign pop       = (state_q == S_IDLE) && tok_valid;

	always_comb begin
		raddr_x = XW'(cur_q);
		qaddr   = '0;
		pool_we = 1'b0;
		waddr_x = XW'(free_q);
		wdata   = 8'd0;
		unique case (state_q)
			S_LEN1: raddr_x = XW'(cur_q) + XW'(1);
			S_CMP: begin
				raddr_x = hit_off + XW'(k_q);
				qaddr   = k_q[QIW-1:0];
			end
			S_WLO: begin
				pool_we = 1'b1;
				wdata   = qlen16[7:0];
			end
			S_WHI: begin
				pool_we = 1'b1;
				waddr_x = XW'(free_q) + XW'(1);
				wdata   = qlen16[15:8];
			end
			S_WCH: begin
				pool_we = 1'b1;
				qaddr   = kp1[QIW-1:0];
				if (k_q < qlen_q) begin
					waddr_x = new_off + XW'(k_q);
					wdata   = qdata_q;
				end else begin
					waddr_x = new_off + XW'(qlen_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= pool_mem[raddr_x[AW-1:0]];
		rlow_q  <= (raddr_x < XW'(sifa_pkg::FREE_RESET));
		if (pool_we)
			pool_mem[waddr_x[AW-1:0]] <= wdata;
	end

	always_ff @(posedge clk) begin
		qdata_q <= qbuf_mem[qaddr];
		if (pop && tok.has_byte)
			qbuf_mem[qlen_q[QIW-1:0]] <= tok.byte_value;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && emit_ok) begin
			out_off_q   <= off_q;
			out_added_q <= added_q;
			out_full_q  <= full_q;
			out_long_q  <= long_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.string_offset = out_off_q;
	assign rsp.was_added     = out_added_q;
	assign rsp.pool_full     = out_full_q;
	assign rsp.too_long      = out_long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_q      <= FW'(sifa_pkg::FREE_RESET);
			cur_q       <= '0;
			qlen_q      <= '0;
			k_q         <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EMIT && emit_ok)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (tok_valid) begin
						if (tok.has_byte)
							qlen_q <= qlen_q + LW'(1);
						if (tok.end_of_string) begin
							if (tok.overlong) begin
								off_q   <= '0;
								added_q <= 1'b0;
								full_q  <= 1'b0;
								long_q  <= 1'b1;
								state_q <= S_EMIT;
							end else begin
								cur_q   <= '0;
								state_q <= S_LEN0;
							end
						end
					end
				end
				S_LEN0: state_q <= walk_ok ? S_LEN1 : S_FIT;
				S_LEN1: begin
					len_lo_q <= pool_rd;
					state_q  <= S_LEN2;
				end
				S_LEN2: begin
					len_q <= len16;
					if (len16 == qlen16 && qlen_q == '0) begin
						off_q   <= hit_off[OB-1:0];
						added_q <= 1'b0;
						full_q  <= 1'b0;
						long_q  <= 1'b0;
						state_q <= S_EMIT;
					end else if (len16 == qlen16) begin
						k_q     <= '0;
						pend_q  <= 1'b0;
						state_q <= S_CMP;
					end else begin
						cur_q   <= nxt_even[FW-1:0];
						state_q <= S_LEN0;
					end
				end
				S_CMP: begin
					if (pend_q && pool_rd != qdata_q) begin
						cur_q   <= nxt_even[FW-1:0];
						state_q <= S_LEN0;
					end else if (k_q == qlen_q) begin
						off_q   <= hit_off[OB-1:0];
						added_q <= 1'b0;
						full_q  <= 1'b0;
						long_q  <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						k_q    <= kp1;
						pend_q <= 1'b1;
					end
				end
				S_FIT: begin
					if (need_x > XW'(sifa_pkg::POOL_BYTES)) begin
						off_q   <= '0;
						added_q <= 1'b0;
						full_q  <= 1'b1;
						long_q  <= 1'b0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_WLO;
					end
				end
				S_WLO: state_q <= S_WHI;
				S_WHI: begin
					k_q     <= '0;
					state_q <= S_WCH;
				end
				S_WCH: begin
					if (k_q < qlen_q) begin
						k_q <= kp1;
					end else begin
						off_q   <= new_off[OB-1:0];
						added_q <= 1'b1;
						full_q  <= 1'b0;
						long_q  <= 1'b0;
						free_q  <= need_even[FW-1:0];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_ok) begin
						qlen_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
